### hw/rtl/scfla_pkg.sv
// Shared types, constants and the helper function of the size-class allocator.
`default_nettype none
package scfla_pkg;

  localparam int ADDR_W      = 18;
  localparam int GRAN_W      = 14;
  localparam int CLS_W       = 4;
  localparam int NUM_CLASSES = 12;
  localparam int POOL_CHUNKS = 16;
  localparam int CARVED_W    = 5;
  localparam int CHUNK_IDX_W = 4;
  localparam int CHUNK_GRAN_W = 10;
  localparam int COPY_W      = 14;
  localparam int REQ_W       = 32;
  localparam int MAX_W       = 15;
  localparam logic [REQ_W-1:0] TOO_BIG_LIMIT = 32'd16368;
  localparam logic [MAX_W-1:0] HEADER_BYTES  = 15'd16;
  localparam logic [CARVED_W-1:0] RESET_AVAIL = 5'd16;

  typedef enum logic [1:0] {
    MODE_ALLOC   = 2'd0,
    MODE_FREE    = 2'd1,
    MODE_REALLOC = 2'd2,
    MODE_RELEASE = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_OOM     = 3'd1,
    ST_TOO_BIG = 3'd2,
    ST_REJECT  = 3'd3,
    ST_NULL    = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    RES_NONE   = 2'd0,
    RES_STATUS = 2'd1,
    RES_KEEP   = 2'd2,
    RES_TAKE   = 2'd3
  } res_kind_t;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_DECODE, S_CHECK, S_CARVE, S_TAKE_RD, S_TAKE, S_GIVE, S_WIPE, S_FINISH
  } state_t;

  typedef struct packed {
    logic      load;
    logic      wipe_start;
    logic      wipe_step;
    logic      carve_start;
    logic      carve_step;
    logic      take;
    logic      give;
    res_kind_t res;
    status_t   code;
    logic      out_load;
  } sca_cmd_t;

  typedef struct packed {
    mode_t mode;
    logic  is_null;
    logic  too_big;
    logic  head_ok;
    logic  carve_ok;
    logic  addr_ok;
    logic  in_use;
    logic  keep;
    logic  carve_last;
    logic  wipe_last;
    logic  out_busy;
  } sca_stat_t;

  // Smallest class whose block holds need bytes, given need - 1.
  function automatic logic [CLS_W-1:0] class_of(input logic [GRAN_W-1:0] nm1);
    logic [CLS_W-1:0] len;
    len = '0;
    for (int i = 0; i < GRAN_W; i++) begin
      if (nm1[i]) len = CLS_W'(i + 1);
    end
    if (len < 4'd4) len = 4'd4;
    return len - 4'd3;
  endfunction

endpackage
`default_nettype wire

### hw/rtl/scfla_datapath.sv
// Datapath of the allocator: list heads, link and in-use memories, result registers.
`default_nettype none
module scfla_datapath (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire scfla_pkg::sca_cmd_t         cmd,
  output scfla_pkg::sca_stat_t             stat,
  input  wire [1:0]                        in_mode,
  input  wire [scfla_pkg::REQ_W-1:0]       in_req,
  input  wire [scfla_pkg::ADDR_W-1:0]      in_addr,
  input  wire                              cfg_valid,
  input  wire [scfla_pkg::CARVED_W-1:0]    cfg_data,
  input  wire                              out_ready,
  output logic                             out_valid,
  output logic [2:0]                       out_status,
  output logic [scfla_pkg::ADDR_W-1:0]     out_addr,
  output logic [scfla_pkg::COPY_W-1:0]     out_copy,
  output logic                             out_moved,
  output logic [scfla_pkg::CLS_W-1:0]      out_cls
);

  localparam int GRAN = 1 << scfla_pkg::GRAN_W;

  scfla_pkg::mode_t                  mode_r;
  logic [scfla_pkg::REQ_W-1:0]       req_r;
  logic [scfla_pkg::ADDR_W-1:0]      addr_r;
  logic [scfla_pkg::GRAN_W-1:0]      heads_r [scfla_pkg::NUM_CLASSES];
  logic [scfla_pkg::NUM_CLASSES-1:0] hv_r;
  logic [scfla_pkg::CLS_W-1:0]       cc_r [scfla_pkg::POOL_CHUNKS];
  logic [scfla_pkg::CARVED_W-1:0]    carved_r, avail_r;
  logic [scfla_pkg::GRAN_W-1:0]      cur_r, wipe_cnt_r;
  logic [scfla_pkg::GRAN_W:0]        link_mem [GRAN];
  logic                              inuse_mem [GRAN];
  logic [scfla_pkg::GRAN_W:0]        link_q_r;
  logic                              inuse_q_r;
  logic [2:0]                        res_status_r;
  logic [scfla_pkg::ADDR_W-1:0]      res_addr_r;
  logic [scfla_pkg::COPY_W-1:0]      res_copy_r;
  logic                              res_moved_r;
  logic [scfla_pkg::CLS_W-1:0]       res_cls_r;
  logic                              out_valid_r;

  logic [scfla_pkg::REQ_W:0]         need;
  logic                              too_big;
  logic [scfla_pkg::CLS_W-1:0]       cidx, oc;
  logic [scfla_pkg::GRAN_W-1:0]      g_in, head_g;
  logic [scfla_pkg::CHUNK_IDX_W-1:0] k_in;
  logic [scfla_pkg::MAX_W-1:0]       old_max, keep_bytes;
  logic [scfla_pkg::COPY_W-1:0]      copy_len;
  logic [scfla_pkg::GRAN_W:0]        step, next_g;
  logic                              carve_last, moved;
  logic                              iu_we, iu_wd;
  logic [scfla_pkg::GRAN_W-1:0]      iu_wa;

  assign need    = {1'b0, req_r} + 33'd16;
  assign too_big = req_r >= scfla_pkg::TOO_BIG_LIMIT;
  assign cidx    = too_big ? '0 : scfla_pkg::class_of(need[scfla_pkg::GRAN_W-1:0] - 14'd1);
  assign head_g  = heads_r[cidx];
  assign g_in    = addr_r[scfla_pkg::ADDR_W-1:4] - 14'd1;
  assign k_in    = g_in[scfla_pkg::GRAN_W-1:scfla_pkg::CHUNK_GRAN_W];
  assign oc      = cc_r[k_in];
  assign old_max = scfla_pkg::MAX_W'(1) << (oc + 4'd3);
  assign keep_bytes = old_max - scfla_pkg::HEADER_BYTES;
  assign copy_len = (req_r < {17'd0, keep_bytes}) ? req_r[scfla_pkg::COPY_W-1:0]
                                                  : keep_bytes[scfla_pkg::COPY_W-1:0];
  assign moved   = (mode_r == scfla_pkg::MODE_REALLOC) && (addr_r != '0);
  assign step    = (scfla_pkg::GRAN_W+1)'(1) << (cidx - 4'd1);
  assign next_g  = {1'b0, cur_r} + step;
  // A run ends at the chunk boundary, or before a block whose user address leaves the space.
  assign carve_last = (next_g[scfla_pkg::CHUNK_GRAN_W-1:0] == '0) ||
                      (next_g >= 15'(GRAN - 1));

  always_comb begin
    stat.mode       = mode_r;
    stat.is_null    = addr_r == '0;
    stat.too_big    = too_big;
    stat.head_ok    = hv_r[cidx];
    stat.carve_ok   = (carved_r < avail_r) && (carved_r < 5'(scfla_pkg::POOL_CHUNKS));
    stat.addr_ok    = (addr_r[scfla_pkg::ADDR_W-1:4] != '0) && (addr_r[3:0] == 4'd0) &&
                      ({1'b0, k_in} < carved_r);
    stat.in_use     = inuse_q_r;
    stat.keep       = ({18'd0, old_max} >= need) && !(need < {19'd0, old_max[14:1]});
    stat.carve_last = carve_last;
    stat.wipe_last  = &wipe_cnt_r;
    stat.out_busy   = out_valid_r && !out_ready;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= scfla_pkg::mode_t'(in_mode);
      req_r  <= in_req;
      addr_r <= in_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hv_r        <= '0;
      carved_r    <= '0;
      avail_r     <= scfla_pkg::RESET_AVAIL;
      wipe_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) avail_r <= cfg_data;
      if (cmd.wipe_start) begin
        hv_r       <= '0;
        carved_r   <= '0;
        wipe_cnt_r <= '0;
      end
      if (cmd.wipe_step) wipe_cnt_r <= wipe_cnt_r + 14'd1;
      if (cmd.carve_start) begin
        hv_r[cidx] <= 1'b1;
        carved_r   <= carved_r + 5'd1;
      end
      if (cmd.take) hv_r[cidx] <= link_q_r[scfla_pkg::GRAN_W];
      if (cmd.give) hv_r[oc] <= 1'b1;
      if (cmd.out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.carve_start) begin
      heads_r[cidx] <= {carved_r[scfla_pkg::CHUNK_IDX_W-1:0], 10'd0};
      cc_r[carved_r[scfla_pkg::CHUNK_IDX_W-1:0]] <= cidx;
      cur_r <= {carved_r[scfla_pkg::CHUNK_IDX_W-1:0], 10'd0};
    end
    if (cmd.carve_step) cur_r <= next_g[scfla_pkg::GRAN_W-1:0];
    if (cmd.take) heads_r[cidx] <= link_q_r[scfla_pkg::GRAN_W-1:0];
    if (cmd.give) heads_r[oc] <= g_in;
  end

  // Link memory: one write, one registered read per cycle.
  always_ff @(posedge clk) begin
    if (cmd.carve_step) begin
      link_mem[cur_r] <= {!carve_last, next_g[scfla_pkg::GRAN_W-1:0]};
    end else if (cmd.give) begin
      link_mem[g_in] <= {hv_r[oc], heads_r[oc]};
    end
    link_q_r <= link_mem[head_g];
  end

  always_comb begin
    iu_we = 1'b0;
    iu_wa = g_in;
    iu_wd = 1'b0;
    priority if (cmd.wipe_step) begin
      iu_we = 1'b1;
      iu_wa = wipe_cnt_r;
    end else if (cmd.take) begin
      iu_we = 1'b1;
      iu_wa = head_g;
      iu_wd = 1'b1;
    end else if (cmd.give) begin
      iu_we = 1'b1;
    end else begin
      iu_we = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (iu_we) inuse_mem[iu_wa] <= iu_wd;
    inuse_q_r <= inuse_mem[g_in];
  end

  always_ff @(posedge clk) begin
    unique case (cmd.res)
      scfla_pkg::RES_STATUS: begin
        res_status_r <= cmd.code;
        res_addr_r   <= '0;
        res_copy_r   <= '0;
        res_moved_r  <= 1'b0;
        res_cls_r    <= '0;
      end
      scfla_pkg::RES_KEEP: begin
        res_status_r <= scfla_pkg::ST_OK;
        res_addr_r   <= addr_r;
        res_copy_r   <= '0;
        res_moved_r  <= 1'b0;
        res_cls_r    <= oc;
      end
      scfla_pkg::RES_TAKE: begin
        res_status_r <= scfla_pkg::ST_OK;
        res_addr_r   <= {head_g + 14'd1, 4'd0};
        res_copy_r   <= moved ? copy_len : '0;
        res_moved_r  <= moved;
        res_cls_r    <= cidx;
      end
      default: ;
    endcase
    if (cmd.out_load) begin
      out_status <= res_status_r;
      out_addr   <= res_addr_r;
      out_copy   <= res_copy_r;
      out_moved  <= res_moved_r;
      out_cls    <= res_cls_r;
    end
  end

  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  a_carved_bound: assert property (@(posedge clk) disable iff (!rst_n)
    carved_r <= 5'(scfla_pkg::POOL_CHUNKS)) else $error("carved count above pool size");
  a_take_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.take |-> hv_r[cidx]) else $error("pop from an empty free list");
  a_wipe_resets: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wipe_start |=> carved_r == '0 && hv_r == '0) else $error("release did not clear");
  a_carve_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.carve_start |-> carved_r < avail_r) else $error("carve beyond available chunks");
`endif

endmodule
`default_nettype wire

### hw/rtl/scfla_ctrl.sv
// Controller state machine of the allocator.
`default_nettype none
module scfla_ctrl (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       in_valid,
  output logic                      in_ready,
  input  wire scfla_pkg::sca_stat_t stat,
  output scfla_pkg::sca_cmd_t       cmd
);

  scfla_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= scfla_pkg::S_INIT;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      scfla_pkg::S_INIT:   if (stat.wipe_last) state_nxt = scfla_pkg::S_IDLE;
      scfla_pkg::S_IDLE:   if (in_valid) state_nxt = scfla_pkg::S_DECODE;
      scfla_pkg::S_DECODE: begin
        priority if (stat.mode == scfla_pkg::MODE_RELEASE) begin
          state_nxt = scfla_pkg::S_WIPE;
        end else if (stat.mode == scfla_pkg::MODE_ALLOC ||
                     (stat.mode == scfla_pkg::MODE_REALLOC && stat.is_null)) begin
          priority if (stat.too_big) state_nxt = scfla_pkg::S_FINISH;
          else if (stat.head_ok)     state_nxt = scfla_pkg::S_TAKE;
          else if (stat.carve_ok)    state_nxt = scfla_pkg::S_CARVE;
          else                       state_nxt = scfla_pkg::S_FINISH;
        end else if (stat.is_null || !stat.addr_ok) begin
          state_nxt = scfla_pkg::S_FINISH;
        end else begin
          state_nxt = scfla_pkg::S_CHECK;
        end
      end
      scfla_pkg::S_CHECK: begin
        priority if (!stat.in_use || stat.mode == scfla_pkg::MODE_FREE || stat.keep ||
                     stat.too_big) state_nxt = scfla_pkg::S_FINISH;
        else if (stat.head_ok)     state_nxt = scfla_pkg::S_TAKE;
        else if (stat.carve_ok)    state_nxt = scfla_pkg::S_CARVE;
        else                       state_nxt = scfla_pkg::S_FINISH;
      end
      scfla_pkg::S_CARVE:   if (stat.carve_last) state_nxt = scfla_pkg::S_TAKE_RD;
      scfla_pkg::S_TAKE_RD: state_nxt = scfla_pkg::S_TAKE;
      scfla_pkg::S_TAKE: begin
        if (stat.mode == scfla_pkg::MODE_REALLOC && !stat.is_null)
          state_nxt = scfla_pkg::S_GIVE;
        else
          state_nxt = scfla_pkg::S_FINISH;
      end
      scfla_pkg::S_GIVE:   state_nxt = scfla_pkg::S_FINISH;
      scfla_pkg::S_WIPE:   if (stat.wipe_last) state_nxt = scfla_pkg::S_FINISH;
      scfla_pkg::S_FINISH: if (!stat.out_busy) state_nxt = scfla_pkg::S_IDLE;
      default:             state_nxt = scfla_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.res  = scfla_pkg::RES_NONE;
    cmd.code = scfla_pkg::ST_OK;
    in_ready = 1'b0;
    unique case (state_r)
      scfla_pkg::S_INIT: cmd.wipe_step = 1'b1;
      scfla_pkg::S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      scfla_pkg::S_DECODE: begin
        priority if (stat.mode == scfla_pkg::MODE_RELEASE) begin
          cmd.wipe_start = 1'b1;
          cmd.res = scfla_pkg::RES_STATUS;
        end else if (stat.mode == scfla_pkg::MODE_ALLOC ||
                     (stat.mode == scfla_pkg::MODE_REALLOC && stat.is_null)) begin
          priority if (stat.too_big) begin
            cmd.res = scfla_pkg::RES_STATUS;
            cmd.code = scfla_pkg::ST_TOO_BIG;
          end else if (stat.head_ok) begin
          end else if (stat.carve_ok) begin
            cmd.carve_start = 1'b1;
          end else begin
            cmd.res = scfla_pkg::RES_STATUS;
            cmd.code = scfla_pkg::ST_OOM;
          end
        end else if (stat.is_null) begin
          cmd.res = scfla_pkg::RES_STATUS;
          cmd.code = scfla_pkg::ST_NULL;
        end else if (!stat.addr_ok) begin
          cmd.res = scfla_pkg::RES_STATUS;
          cmd.code = scfla_pkg::ST_REJECT;
        end else begin
          // A plausible address goes on to the in-use check.
          cmd.res = scfla_pkg::RES_NONE;
        end
      end
      scfla_pkg::S_CHECK: begin
        priority if (!stat.in_use) begin
          cmd.res = scfla_pkg::RES_STATUS;
          cmd.code = scfla_pkg::ST_REJECT;
        end else if (stat.mode == scfla_pkg::MODE_FREE) begin
          cmd.give = 1'b1;
          cmd.res = scfla_pkg::RES_STATUS;
        end else if (stat.keep) begin
          cmd.res = scfla_pkg::RES_KEEP;
        end else if (stat.too_big) begin
          cmd.res = scfla_pkg::RES_STATUS;
          cmd.code = scfla_pkg::ST_TOO_BIG;
        end else if (stat.head_ok) begin
        end else if (stat.carve_ok) begin
          cmd.carve_start = 1'b1;
        end else begin
          cmd.res = scfla_pkg::RES_STATUS;
          cmd.code = scfla_pkg::ST_OOM;
        end
      end
      scfla_pkg::S_CARVE: cmd.carve_step = 1'b1;
      scfla_pkg::S_TAKE: begin
        cmd.take = 1'b1;
        cmd.res = scfla_pkg::RES_TAKE;
      end
      scfla_pkg::S_GIVE:   cmd.give = 1'b1;
      scfla_pkg::S_WIPE:   cmd.wipe_step = 1'b1;
      scfla_pkg::S_FINISH: cmd.out_load = !stat.out_busy;
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_one_inuse_write: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.take && cmd.give)) else $error("take and give in one cycle");
  a_take_follows: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == scfla_pkg::S_TAKE |=> state_r == scfla_pkg::S_GIVE ||
                                      state_r == scfla_pkg::S_FINISH)
    else $error("pop not followed by give or finish");
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> state_r == scfla_pkg::S_IDLE) else $error("load outside idle");
`endif

endmodule
`default_nettype wire

### hw/rtl/size_class_free_list_allocator.sv
// Top level of the power-of-two size-class free-list allocator.
// Usage:
// One request beat enters on the in_ channel: in_tuser carries the mode
// (allocate, free, reallocate, release all), in_tdata the request size and the
// user address of an existing block. Every request beat yields exactly one
// result beat on the out_ channel: out_tuser carries the status, out_tdata the
// resulting user address, copy length, moved flag and size class.
// Requests are handled one at a time. An allocate from a non-empty list passes
// decode, the pop and the finish state, where its result is loaded into the
// output register, and the next request beat is taken back in idle. Free and
// in-place reallocate pass decode and the in-use check; a null free, a bad
// address or an allocate that is too big or out of memory pass only decode; and a
// moving reallocate passes the in-use check, the pop and a push of the old block.
// Carving a fresh chunk first writes one link word per block of that class (up
// to 1024), then reads the new list head before the pop.
// Release all, and reset, sweep the in-use memory one entry a cycle, all 16384
// entries. After reset no request is taken until that sweep ends; config writes
// on cfg_ are taken at any time and set the number of carvable chunks.
// The result sits in an output register: while the receiver stalls the next
// request is still accepted and worked, and waits only to hand over its result.
`default_nettype none
module size_class_free_list_allocator (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  // [31:0] request_size, [49:32] block_address, [55:50] zero
  input  wire  [55:0] in_tdata,
  // [1:0] mode
  input  wire  [1:0]  in_tuser,
  output logic        out_tvalid,
  input  wire         out_tready,
  // [17:0] address, [31:18] copy_length, [32] moved, [36:33] size_class, [39:37] zero
  output logic [39:0] out_tdata,
  // [2:0] status
  output logic [2:0]  out_tuser,
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [4:0]  cfg_data
);

  scfla_pkg::sca_cmd_t  cmd;
  scfla_pkg::sca_stat_t stat;
  logic [17:0] o_addr;
  logic [13:0] o_copy;
  logic        o_moved;
  logic [3:0]  o_cls;

  // The configuration register takes a beat in any cycle.
  assign cfg_ready = 1'b1;

  scfla_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  scfla_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_mode    (in_tuser),
    .in_req     (in_tdata[31:0]),
    .in_addr    (in_tdata[49:32]),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .out_ready  (out_tready),
    .out_valid  (out_tvalid),
    .out_status (out_tuser),
    .out_addr   (o_addr),
    .out_copy   (o_copy),
    .out_moved  (o_moved),
    .out_cls    (o_cls)
  );

  assign out_tdata = {3'd0, o_cls, o_moved, o_copy, o_addr};

endmodule
`default_nettype wire
